// ----- sv/pmtr_pkg.sv -----
package pmtr_pkg;

    localparam int MAX_DIM    = 64;
    localparam int DIM_BITS   = $clog2(MAX_DIM);
    localparam int CNT_BITS   = DIM_BITS + 1;
    localparam int ADDR_BITS  = 2 * DIM_BITS;
    localparam int PIX_BITS   = 8;
    localparam int TDATA_BITS = ((PIX_BITS + 7) / 8) * 8;
    localparam int CFG_W      = 7;
    localparam int IDX_BITS   = 2;

    // Configuration register indexes.
    localparam logic [IDX_BITS-1:0] REG_IMAGE_ROWS   = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_IMAGE_COLS   = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_REORDER_MODE = 2'd2;

    // Item commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Reorder modes.
    localparam logic MODE_TRANSPOSE = 1'b0;
    localparam logic MODE_ROTATE    = 1'b1;

    typedef struct packed {
        logic pix_write;
        logic pix_read;
    } pmtr_cmd_t;

    // A dimension of zero acts as one, one above MAX_DIM acts as MAX_DIM.
    function automatic logic [CNT_BITS-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [CNT_BITS-1:0] r;
        if (v == '0) begin
            r = CNT_BITS'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = CNT_BITS'(MAX_DIM);
        end else begin
            r = CNT_BITS'(v);
        end
        return r;
    endfunction

endpackage

// ----- sv/pmtr_ctrl.sv -----
module pmtr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                command,
    output logic                m_tvalid,
    input  logic                m_tready,
    output pmtr_pkg::pmtr_cmd_t cmd
);

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg;
    logic state_next;
    logic s_acc;

    // An item is taken whenever the output register is free or being drained.
    assign s_tready      = (state_reg == ST_EMPTY) || m_tready;
    assign s_acc         = s_tvalid && s_tready;
    assign cmd.pix_write = s_acc && (command == pmtr_pkg::CMD_WRITE);
    assign cmd.pix_read  = s_acc && (command == pmtr_pkg::CMD_READ);
    assign m_tvalid      = (state_reg == ST_FULL);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY: begin
                if (cmd.pix_read) begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL: begin
                if (cmd.pix_read) begin
                    state_next = ST_FULL;
                end else if (m_tready) begin
                    state_next = ST_EMPTY;
                end
            end
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    a_read_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pix_read |=> m_tvalid)
        else $error("accepted read did not produce a result");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !cmd.pix_read) |=> !m_tvalid)
        else $error("result repeated after it was taken");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.pix_write && cmd.pix_read))
        else $error("write and read issued together");

endmodule

// ----- sv/pmtr_datapath.sv -----
module pmtr_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_en,
    input  logic [pmtr_pkg::IDX_BITS-1:0]      cfg_index,
    input  logic [pmtr_pkg::CFG_W-1:0]         cfg_data,
    input  pmtr_pkg::pmtr_cmd_t                cmd,
    input  logic [pmtr_pkg::PIX_BITS-1:0]      pixel_in,
    output logic [pmtr_pkg::PIX_BITS-1:0]      pixel_out,
    output logic                               row_end,
    output logic                               frame_end
);

    logic [pmtr_pkg::CFG_W-1:0]     image_rows_reg;
    logic [pmtr_pkg::CFG_W-1:0]     image_cols_reg;
    logic                           reorder_mode_reg;
    logic [pmtr_pkg::DIM_BITS-1:0]  write_row_reg;
    logic [pmtr_pkg::DIM_BITS-1:0]  write_col_reg;
    logic [pmtr_pkg::DIM_BITS-1:0]  read_row_reg;
    logic [pmtr_pkg::DIM_BITS-1:0]  read_col_reg;
    logic [pmtr_pkg::PIX_BITS-1:0]  pixel_out_reg;
    logic                           row_end_reg;
    logic                           frame_end_reg;

    logic [pmtr_pkg::PIX_BITS-1:0]  frame_mem [pmtr_pkg::MAX_DIM * pmtr_pkg::MAX_DIM];

    logic [pmtr_pkg::CNT_BITS-1:0]  rows_eff;
    logic [pmtr_pkg::CNT_BITS-1:0]  cols_eff;
    logic                           wr_col_last;
    logic                           wr_row_last;
    logic                           rd_row_end;
    logic                           rd_frame_end;
    logic [pmtr_pkg::CNT_BITS-1:0]  rot_row;
    logic [pmtr_pkg::DIM_BITS-1:0]  src_row;
    logic [pmtr_pkg::ADDR_BITS-1:0] wr_addr;
    logic [pmtr_pkg::ADDR_BITS-1:0] rd_addr;

    assign rows_eff = pmtr_pkg::eff_dim(image_rows_reg);
    assign cols_eff = pmtr_pkg::eff_dim(image_cols_reg);

    assign wr_col_last  = ({1'b0, write_col_reg} + 1'b1) >= cols_eff;
    assign wr_row_last  = ({1'b0, write_row_reg} + 1'b1) >= rows_eff;
    assign rd_row_end   = ({1'b0, read_col_reg} + 1'b1) >= rows_eff;
    assign rd_frame_end = rd_row_end && (({1'b0, read_row_reg} + 1'b1) >= cols_eff);

    // Result (r,c) comes from source (c,r), or from (rows-1-c, r) when rotating.
    assign rot_row = rows_eff - 1'b1 - {1'b0, read_col_reg};
    assign src_row = (reorder_mode_reg == pmtr_pkg::MODE_ROTATE) ?
                     rot_row[pmtr_pkg::DIM_BITS-1:0] : read_col_reg;
    assign wr_addr = {write_row_reg, write_col_reg};
    assign rd_addr = {src_row, read_row_reg};

    always_ff @(posedge aclk) begin
        if (cmd.pix_write) begin
            frame_mem[wr_addr] <= pixel_in;
        end
        if (cmd.pix_read) begin
            pixel_out_reg <= frame_mem[rd_addr];
            row_end_reg   <= rd_row_end;
            frame_end_reg <= rd_frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_rows_reg   <= pmtr_pkg::CFG_W'(1);
            image_cols_reg   <= pmtr_pkg::CFG_W'(1);
            reorder_mode_reg <= pmtr_pkg::MODE_TRANSPOSE;
            write_row_reg    <= '0;
            write_col_reg    <= '0;
            read_row_reg     <= '0;
            read_col_reg     <= '0;
        end else if (cfg_en && (cfg_index == pmtr_pkg::REG_IMAGE_ROWS ||
                                cfg_index == pmtr_pkg::REG_IMAGE_COLS ||
                                cfg_index == pmtr_pkg::REG_REORDER_MODE)) begin
            // Any register write restarts both positions; the store keeps its data.
            unique case (cfg_index)
                pmtr_pkg::REG_IMAGE_ROWS:   image_rows_reg   <= cfg_data;
                pmtr_pkg::REG_IMAGE_COLS:   image_cols_reg   <= cfg_data;
                pmtr_pkg::REG_REORDER_MODE: reorder_mode_reg <= cfg_data[0];
                default: ;
            endcase
            write_row_reg <= '0;
            write_col_reg <= '0;
            read_row_reg  <= '0;
            read_col_reg  <= '0;
        end else begin
            if (cmd.pix_write) begin
                if (wr_col_last) begin
                    write_col_reg <= '0;
                    write_row_reg <= wr_row_last ? '0 : write_row_reg + 1'b1;
                end else begin
                    write_col_reg <= write_col_reg + 1'b1;
                end
            end
            if (cmd.pix_read) begin
                if (rd_row_end) begin
                    read_col_reg <= '0;
                    read_row_reg <= rd_frame_end ? '0 : read_row_reg + 1'b1;
                end else begin
                    read_col_reg <= read_col_reg + 1'b1;
                end
            end
        end
    end

    assign pixel_out = pixel_out_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

    a_write_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, write_col_reg} < cols_eff) && ({1'b0, write_row_reg} < rows_eff))
        else $error("write position left the frame");

    a_read_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, read_col_reg} < rows_eff) && ({1'b0, read_row_reg} < cols_eff))
        else $error("read position left the result frame");

    a_frame_end_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pix_read && rd_frame_end && !cfg_en) |=>
            (read_row_reg == '0) && (read_col_reg == '0))
        else $error("read position did not wrap at frame end");

endmodule

// ----- sv/pixel_matrix_transpose_rotate.sv -----
// Frame reorder engine: transposes or turns 90 degrees clockwise an 8-bit
// image of up to 64 by 64 pixels held in an on-chip frame store.
// Input channel (s_): s_tuser[0] is the command, 0 to write the next source
// pixel (s_tdata, row-major) and 1 to read the next result pixel. Writes
// produce nothing; each read produces one item on the output channel (m_)
// with the pixel in m_tdata, m_tlast marking the end of a result row and
// m_tuser[0] the last pixel of the frame. The result image has image_cols
// rows of image_rows pixels. A frame must be completely written before it
// is read.
// A read's result is registered and valid in the cycle after it is accepted. The
// block takes one item per cycle while the receiver does not stall; the frame
// store does one write or one read per item.
// The cfg channel is always ready; index 0 sets image_rows, 1 image_cols,
// 2 the mode (0 transpose, 1 rotate). Any register write restarts the write
// and read positions. Reset sets both dimensions to 1, transpose mode and
// all positions to zero; the store is not cleared.
// While the receiver stalls, the result holds in the output register and
// s_tready drops, so no further item is taken until the result is taken.
module pixel_matrix_transpose_rotate (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pmtr_pkg::TDATA_BITS-1:0]      s_tdata,   // [7:0] pixel_in
    input  logic [0:0]                           s_tuser,   // [0] command
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pmtr_pkg::TDATA_BITS-1:0]      m_tdata,   // [7:0] pixel_out
    output logic                                 m_tlast,   // row_end
    output logic [0:0]                           m_tuser,   // [0] frame_end
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pmtr_pkg::IDX_BITS-1:0]        cfg_index,
    input  logic [pmtr_pkg::CFG_W-1:0]           cfg_data
);

    pmtr_pkg::pmtr_cmd_t           cmd;
    logic [pmtr_pkg::PIX_BITS-1:0] pixel_out;
    logic                          frame_end;

    assign cfg_ready = 1'b1;

    pmtr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pmtr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_en    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .pixel_in  (s_tdata[pmtr_pkg::PIX_BITS-1:0]),
        .pixel_out (pixel_out),
        .row_end   (m_tlast),
        .frame_end (frame_end)
    );

    assign m_tdata    = pmtr_pkg::TDATA_BITS'(pixel_out);
    assign m_tuser[0] = frame_end;

endmodule

// ----- tb/sv/pixel_matrix_transpose_rotate_checker.sv -----
`timescale 1ns / 1ps

module pixel_matrix_transpose_rotate_checker
    import pmtr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // [7:0] pixel_in
    input  logic [0:0]            s_tuser,   // [0] command
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_BITS-1:0] m_tdata,   // [7:0] pixel_out
    input  logic                  m_tlast,
    input  logic [0:0]            m_tuser,   // [0] frame_end
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    checked_count
);

    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic                row_end;
        logic                frame_end;
    } reordered_pixel_t;

    logic [PIX_BITS-1:0] frame_copy [MAX_DIM*MAX_DIM];
    logic [CFG_W-1:0]    rows_reg;
    logic [CFG_W-1:0]    cols_reg;
    logic                mode_reg;
    int                  wr_row, wr_col, rd_row, rd_col;
    reordered_pixel_t    expected_pixels [$];

    function automatic int dim_used(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        if (fail_count < PRINT_LIMIT) begin
            $display("ERROR at %0t ns: %s, expected %0d, got %0d", $time, what, want, got);
        end
        fail_count++;
    endtask

    always @(posedge aclk) begin : predict
        int               rows;
        int               cols;
        int               src_row;
        bit               restart;
        reordered_pixel_t got;
        reordered_pixel_t want;
        if (!aresetn) begin
            rows_reg = CFG_W'(1);
            cols_reg = CFG_W'(1);
            mode_reg = MODE_TRANSPOSE;
            wr_row = 0;
            wr_col = 0;
            rd_row = 0;
            rd_col = 0;
            expected_pixels.delete();
        end else begin
            // A read's result is registered and leaves only after the read, so results
            // are matched before this edge's item is predicted.
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[PIX_BITS-1:0], m_tlast, m_tuser[0]};
                checked_count++;
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result item with none expected, pixel_out", -1, got.pixel);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.pixel !== want.pixel) begin
                        report_mismatch("pixel_out", want.pixel, got.pixel);
                    end
                    if (got.row_end !== want.row_end) begin
                        report_mismatch("row_end (m_tlast)", want.row_end, got.row_end);
                    end
                    if (got.frame_end !== want.frame_end) begin
                        report_mismatch("frame_end (m_tuser)", want.frame_end, got.frame_end);
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                restart = 1'b1;
                case (cfg_index)
                    REG_IMAGE_ROWS:   rows_reg = cfg_data;
                    REG_IMAGE_COLS:   cols_reg = cfg_data;
                    REG_REORDER_MODE: mode_reg = cfg_data[0];
                    default:          restart = 1'b0;
                endcase
                if (restart) begin
                    wr_row = 0;
                    wr_col = 0;
                    rd_row = 0;
                    rd_col = 0;
                end
            end

            if (s_tvalid && s_tready) begin
                rows = dim_used(rows_reg);
                cols = dim_used(cols_reg);
                if (s_tuser[0] == CMD_WRITE) begin
                    frame_copy[wr_row*MAX_DIM + wr_col] = s_tdata[PIX_BITS-1:0];
                    if (wr_col + 1 >= cols) begin
                        wr_col = 0;
                        wr_row = (wr_row + 1 >= rows) ? 0 : wr_row + 1;
                    end else begin
                        wr_col++;
                    end
                end else begin
                    // The result image has cols rows of rows pixels each.
                    src_row = (mode_reg == MODE_ROTATE) ? rows - 1 - rd_col : rd_col;
                    want.pixel     = frame_copy[src_row*MAX_DIM + rd_row];
                    want.row_end   = (rd_col + 1 >= rows);
                    want.frame_end = want.row_end && (rd_row + 1 >= cols);
                    expected_pixels.push_back(want);
                    if (want.row_end) begin
                        rd_col = 0;
                        rd_row = want.frame_end ? 0 : rd_row + 1;
                    end else begin
                        rd_col++;
                    end
                end
            end
        end
        pending = expected_pixels.size();
    end

endmodule

// ----- tb/sv/pixel_matrix_transpose_rotate_tb.sv -----
`timescale 1ns / 1ps

module pixel_matrix_transpose_rotate_tb;
    import pmtr_pkg::*;

    localparam int ITEM_GOAL    = 1100;
    localparam int DRAIN_CYCLES = 4;
    localparam int STORE_SIZE   = MAX_DIM * MAX_DIM;
    localparam int LIMIT_NS     = 2_000_000;

    // Index past the register list; the block must ignore it.
    localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_BURSTY
    } sink_style_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata   = '0;   // [7:0] pixel_in
    logic [0:0]            s_tuser   = '0;   // [0] command
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;          // [7:0] pixel_out
    logic                  m_tlast;
    logic [0:0]            m_tuser;          // [0] frame_end
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    int fail_count;
    int pending;
    int checked_count;

    // Stimulus-side view of the frame, used to keep every read on a written entry.
    bit          written [STORE_SIZE];
    int          rows_eff  = 1;
    int          cols_eff  = 1;
    logic        rotate_on = MODE_TRANSPOSE;
    int          wr_row, wr_col, rd_row, rd_col;
    int          burst_left, writes_sent, reads_sent, phases;
    bit          gapless;
    sink_style_t sink_style = SINK_ALWAYS;
    int          sink_hold  = 0;
    logic        sink_on    = 1'b0;

    pixel_matrix_transpose_rotate dut (.*);

    pixel_matrix_transpose_rotate_checker reorder_check (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        case (sink_style)
            SINK_ALWAYS: m_tready <= 1'b1;
            SINK_RANDOM: m_tready <= ($urandom_range(0, 2) != 0);
            default: begin
                if (sink_hold == 0) begin
                    sink_on   = ~sink_on;
                    sink_hold = sink_on ? $urandom_range(1, 8) : $urandom_range(1, 12);
                end
                sink_hold--;
                m_tready <= sink_on;
            end
        endcase
    end

    function automatic bit read_is_safe();
        int src_row;
        src_row = rotate_on ? rows_eff - 1 - rd_col : rd_col;
        return written[src_row*MAX_DIM + rd_row];
    endfunction

    function automatic logic [PIX_BITS-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_item(input logic cmd, input logic [PIX_BITS-1:0] pix);
        int gap;
        if (burst_left == 0) begin
            if (gapless) begin
                burst_left = 1_000_000;
            end else begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_WRITE) begin
            written[wr_row*MAX_DIM + wr_col] = 1'b1;
            writes_sent++;
            if (wr_col + 1 >= cols_eff) begin
                wr_col = 0;
                wr_row = (wr_row + 1 >= rows_eff) ? 0 : wr_row + 1;
            end else begin
                wr_col++;
            end
        end else begin
            reads_sent++;
            if (rd_col + 1 >= rows_eff) begin
                rd_col = 0;
                rd_row = (rd_row + 1 >= cols_eff) ? 0 : rd_row + 1;
            end else begin
                rd_col++;
            end
        end
    endtask

    // Holds the input channel idle until every read has returned its result.
    task automatic drain();
        @(negedge aclk);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [IDX_BITS-1:0] idx, input logic [CFG_W-1:0] value);
        bit restart;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        restart = 1'b1;
        case (idx)
            REG_IMAGE_ROWS:   rows_eff = (value == '0) ? 1 : (int'(value) > MAX_DIM) ?
                                         MAX_DIM : int'(value);
            REG_IMAGE_COLS:   cols_eff = (value == '0) ? 1 : (int'(value) > MAX_DIM) ?
                                         MAX_DIM : int'(value);
            REG_REORDER_MODE: rotate_on = value[0];
            default:          restart = 1'b0;
        endcase
        if (restart) begin
            wr_row = 0;
            wr_col = 0;
            rd_row = 0;
            rd_col = 0;
        end
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                             input logic mode, input bit add_unused);
        logic [IDX_BITS-1:0] order [3];
        logic [CFG_W-1:0]    value [3];
        int                  first;
        order = '{REG_IMAGE_ROWS, REG_IMAGE_COLS, REG_REORDER_MODE};
        value = '{rows, cols, CFG_W'(mode)};
        first = $urandom_range(0, 2);
        drain();
        for (int k = 0; k < 3; k++) begin
            cfg_write(order[(first + k) % 3], value[(first + k) % 3]);
        end
        if (add_unused) begin
            cfg_write(REG_UNUSED, CFG_W'($urandom_range(0, 127)));
        end
        phases++;
    endtask

    task automatic write_frame();
        repeat (rows_eff * cols_eff) send_item(CMD_WRITE, pick_pixel());
    endtask

    task automatic read_frame();
        repeat (rows_eff * cols_eff) send_item(CMD_READ, pick_pixel());
    endtask

    // Random mix of writes and reads; a read whose entry is still unwritten
    // becomes a write instead.
    task automatic mixed_traffic(input int count);
        logic cmd;
        repeat (count) begin
            cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
            if (cmd == CMD_READ && !read_is_safe()) begin
                cmd = CMD_WRITE;
            end
            send_item(cmd, pick_pixel());
        end
    endtask

    initial begin
        #(LIMIT_NS);
        $display("Timeout: %0d reads still waiting for a result.", pending);
        $display("** pixel_matrix_transpose_rotate: FAILED **");
        $finish;
    end

    initial begin
        int               kind;
        logic [CFG_W-1:0] r;
        logic [CFG_W-1:0] c;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: reset setting, dimension of zero, rotate, an ignored
        // register index in the middle of a frame, and a mid-frame pause.
        sink_style = SINK_RANDOM;
        send_item(CMD_WRITE, 8'hFF);
        send_item(CMD_READ, 8'h00);

        set_frame(7'd0, 7'd2, MODE_ROTATE, 1'b0);
        send_item(CMD_WRITE, 8'h00);
        send_item(CMD_WRITE, 8'h80);
        read_frame();

        set_frame(7'd2, 7'd3, MODE_ROTATE, 1'b0);
        for (int k = 0; k < 6; k++) begin
            send_item(CMD_WRITE, 8'h01 << k);
        end
        drain();
        cfg_write(REG_UNUSED, 7'h7F);
        read_frame();

        set_frame(7'd2, 7'd2, MODE_TRANSPOSE, 1'b0);
        send_item(CMD_WRITE, 8'h40);
        send_item(CMD_WRITE, 8'hBF);
        send_item(CMD_WRITE, 8'h7F);
        send_item(CMD_WRITE, 8'hC3);
        send_item(CMD_READ, 8'hFF);
        send_item(CMD_READ, 8'h00);
        drain();
        send_item(CMD_READ, 8'hFF);
        send_item(CMD_READ, 8'h00);

        // Random part: mostly whole frames, some long and thin at the largest
        // dimension, with mixed traffic now and then.
        while (writes_sent + reads_sent < ITEM_GOAL) begin
            kind = $urandom_range(0, 11);
            case (kind)
                0: begin
                    r = $urandom_range(0, 1) ? 7'd64 : CFG_W'($urandom_range(65, 127));
                    c = CFG_W'($urandom_range(0, 2));
                end
                1: begin
                    r = CFG_W'($urandom_range(0, 2));
                    c = $urandom_range(0, 1) ? 7'd64 : CFG_W'($urandom_range(65, 127));
                end
                default: begin
                    r = CFG_W'($urandom_range(0, 8));
                    c = CFG_W'($urandom_range(0, 8));
                end
            endcase
            gapless    = ($urandom_range(0, 3) == 0);
            sink_style = sink_style_t'($urandom_range(0, 2));
            set_frame(r, c, $urandom_range(0, 1) ? MODE_ROTATE : MODE_TRANSPOSE,
                      $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                mixed_traffic($urandom_range(4, 40));
            end else begin
                repeat ($urandom_range(1, 2)) begin
                    write_frame();
                    if ($urandom_range(0, 3) == 0) begin
                        drain();
                    end
                    read_frame();
                end
                if ($urandom_range(0, 3) == 0) begin
                    mixed_traffic($urandom_range(4, 20));
                end
            end
        end

        drain();
        $display("Covered %0d register settings in both modes, %0d pixel writes, %0d pixel reads.",
                 phases, writes_sent, reads_sent);
        $display("Compared %0d result items, with sender gaps and receiver stalls.",
                 checked_count);
        if (fail_count == 0) begin
            $display("** pixel_matrix_transpose_rotate: PASSED **");
        end else begin
            $display("** pixel_matrix_transpose_rotate: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/pmtr_pkg.sv
sv/pmtr_ctrl.sv
sv/pmtr_datapath.sv
sv/pixel_matrix_transpose_rotate.sv
tb/sv/pixel_matrix_transpose_rotate_checker.sv
tb/sv/pixel_matrix_transpose_rotate_tb.sv
